FILE: hw/rtl/plp_pkg.sv
// shared types and constants for the 128-bit integer literal parser
package plp_pkg;

   localparam int CharWidth  = 8;
   localparam int AccWidth   = 128;
   localparam int HalfWidth  = 64;
   localparam int CountWidth = 8;
   localparam int DigitWidth = 4;
   // headroom above the accumulator for the largest multiplier (16)
   localparam int CarryWidth = 4;
   localparam int WideWidth  = AccWidth + CarryWidth;

   localparam logic [CharWidth-1:0]  CHAR_NUL    = 8'h00;
   localparam logic [CharWidth-1:0]  CHAR_ZERO   = 8'h30;  // '0'
   localparam logic [CharWidth-1:0]  CHAR_SEVEN  = 8'h37;  // '7'
   localparam logic [CharWidth-1:0]  CHAR_NINE   = 8'h39;  // '9'
   localparam logic [CharWidth-1:0]  CHAR_UP_A   = 8'h41;  // 'A'
   localparam logic [CharWidth-1:0]  CHAR_UP_F   = 8'h46;  // 'F'
   localparam logic [CharWidth-1:0]  CHAR_LOW_A  = 8'h61;  // 'a'
   localparam logic [CharWidth-1:0]  CHAR_LOW_F  = 8'h66;  // 'f'
   localparam logic [CharWidth-1:0]  CHAR_X      = 8'h78;  // 'x'
   localparam logic [CharWidth-1:0]  LETTER_BIAS = 8'h0A;  // 'a' maps to ten

   localparam logic [CountWidth-1:0] COUNT_MAX = 8'hFF;
   localparam logic [CountWidth-1:0] COUNT_ONE = 8'h01;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_HEX = 2'd1,
      BASE_OCT = 2'd2
   } base_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ZERO   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_byte;
      logic                 start_flag;
   } req_payload_type;

   typedef struct packed {
      logic [HalfWidth-1:0]  value_low;
      logic [HalfWidth-1:0]  value_high;
      logic [1:0]            base_code;
      logic [CountWidth-1:0] digit_count;
      logic                  not_integer;
      logic                  overflowed;
   } rsp_payload_type;

   typedef struct packed {
      logic                  hit;
      logic [DigitWidth-1:0] value;
   } digit_info_type;

endpackage

FILE: hw/rtl/parse_128bit_integer_literal.sv
// top level: input register, parse state update and result register
// an ending character goes through the input register, then into the result register
// throughput: one character beat per cycle; a stalled result blocks only an ending character
// the mac is a 128-bit shift-add, one digit per cycle; no iteration inside a beat
// reset: synchronous, active high; clears both valid flags and all parse state
// characters before the first start_flag beat are dropped without a result
module parse_128bit_integer_literal (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  plp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output plp_pkg::rsp_payload_type rsp_payload
);

   logic                             s1_valid_ff;
   plp_pkg::req_payload_type         s1_payload_ff;
   plp_pkg::phase_type               phase_ff;
   plp_pkg::phase_type               phase_in;
   logic [plp_pkg::AccWidth-1:0]     acc_ff;
   logic [plp_pkg::AccWidth-1:0]     acc_in;
   plp_pkg::base_type                base_ff;
   plp_pkg::base_type                base_in;
   logic [plp_pkg::CountWidth-1:0]   count_ff;
   logic [plp_pkg::CountWidth-1:0]   count_in;
   logic                             wrap_ff;
   logic                             wrap_in;
   logic                             bad_ff;
   logic                             bad_in;
   logic                             rsp_valid_ff;
   plp_pkg::rsp_payload_type         rsp_payload_ff;

   logic                             start;
   logic [plp_pkg::CharWidth-1:0]    chr;
   logic [plp_pkg::AccWidth-1:0]     src_acc;
   plp_pkg::base_type                dec_base;
   plp_pkg::digit_info_type          digit;
   logic [plp_pkg::AccWidth-1:0]     mac_sum;
   logic                             mac_carry;
   logic                             use_mac;
   logic                             emit;
   logic                             out_free;
   logic                             advance;
   logic                             req_accept;

   assign start    = s1_payload_ff.start_flag;
   assign chr      = s1_payload_ff.char_byte;
   // a start beat works on the cleared state
   assign src_acc  = start ? '0 : acc_ff;
   assign dec_base = start ? plp_pkg::BASE_DEC :
                     (phase_ff == plp_pkg::PH_ZERO) ? plp_pkg::BASE_OCT : base_ff;

   plp_digit_decode u_decode (
      .char_byte (chr),
      .base_sel  (dec_base),
      .digit     (digit)
   );

   plp_mac u_mac (
      .acc         (src_acc),
      .base_sel    (dec_base),
      .digit_value (digit.value),
      .sum         (mac_sum),
      .carry       (mac_carry)
   );

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (start) begin
         if (chr == plp_pkg::CHAR_ZERO) begin
            phase_in = plp_pkg::PH_ZERO;
         end else if (digit.hit) begin
            phase_in = plp_pkg::PH_DIGITS;
         end else begin
            phase_in = plp_pkg::PH_IDLE;
         end
      end else begin
         case (phase_ff)
            plp_pkg::PH_ZERO: begin
               if (chr == plp_pkg::CHAR_X) begin
                  phase_in = plp_pkg::PH_DIGITS;
               end else if (chr == plp_pkg::CHAR_NUL) begin
                  phase_in = plp_pkg::PH_IDLE;
               end else if (digit.hit) begin
                  phase_in = plp_pkg::PH_DIGITS;
               end else begin
                  phase_in = plp_pkg::PH_IDLE;
               end
            end
            plp_pkg::PH_DIGITS: begin
               if (!digit.hit) begin
                  phase_in = plp_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // parse state and result
   always_comb begin
      acc_in   = src_acc;
      base_in  = start ? plp_pkg::BASE_DEC : base_ff;
      count_in = start ? '0 : count_ff;
      wrap_in  = start ? 1'b0 : wrap_ff;
      bad_in   = start ? 1'b0 : bad_ff;
      use_mac  = 1'b0;
      emit     = 1'b0;
      if (start) begin
         if (chr == plp_pkg::CHAR_ZERO) begin
            use_mac = 1'b0;
         end else if (digit.hit) begin
            use_mac = 1'b1;
         end else begin
            bad_in = 1'b1;
            emit   = 1'b1;
         end
      end else begin
         case (phase_ff)
            plp_pkg::PH_ZERO: begin
               if (chr == plp_pkg::CHAR_X) begin
                  base_in = plp_pkg::BASE_HEX;
               end else if (chr == plp_pkg::CHAR_NUL) begin
                  // lone zero counts as one digit
                  base_in  = plp_pkg::BASE_DEC;
                  count_in = plp_pkg::COUNT_ONE;
                  emit     = 1'b1;
               end else begin
                  base_in = plp_pkg::BASE_OCT;
                  use_mac = digit.hit;
                  emit    = !digit.hit;
               end
            end
            plp_pkg::PH_DIGITS: begin
               use_mac = digit.hit;
               emit    = !digit.hit;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
      if (use_mac) begin
         acc_in  = mac_sum;
         wrap_in = wrap_in | mac_carry;
         if (count_in != plp_pkg::COUNT_MAX) begin
            count_in = count_in + plp_pkg::COUNT_ONE;
         end
      end
   end

   // an ending character needs room in the result register, others always go
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && (!emit || out_free);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_payload_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= plp_pkg::PH_IDLE;
         acc_ff   <= '0;
         base_ff  <= plp_pkg::BASE_DEC;
         count_ff <= '0;
         wrap_ff  <= 1'b0;
         bad_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         count_ff <= count_in;
         wrap_ff  <= wrap_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && emit) begin
         rsp_payload_ff.value_low   <= acc_in[plp_pkg::HalfWidth-1:0];
         rsp_payload_ff.value_high  <= acc_in[plp_pkg::AccWidth-1:plp_pkg::HalfWidth];
         rsp_payload_ff.base_code   <= base_in;
         rsp_payload_ff.digit_count <= count_in;
         rsp_payload_ff.not_integer <= bad_in;
         rsp_payload_ff.overflowed  <= wrap_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_idle_after_emit: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (phase_ff == plp_pkg::PH_IDLE))
      else $error("parser not idle after ending a number");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (out_free && !(advance && emit)) |=> !rsp_valid_ff)
      else $error("result beat without an ending character");

   a_digits_counted: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == plp_pkg::PH_DIGITS) |->
      ((count_ff != '0) || (base_ff == plp_pkg::BASE_HEX)))
      else $error("digit phase entered without a digit");

   a_bad_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.not_integer) |->
      ((rsp_payload_ff.value_low == '0) && (rsp_payload_ff.value_high == '0) &&
       (rsp_payload_ff.digit_count == '0) && !rsp_payload_ff.overflowed))
      else $error("not_integer result carries a value");
`endif

endmodule

FILE: hw/rtl/plp_digit_decode.sv
// character to digit decode for the selected base
module plp_digit_decode (
   input  logic [plp_pkg::CharWidth-1:0] char_byte,
   input  plp_pkg::base_type             base_sel,
   output plp_pkg::digit_info_type       digit
);

   logic                           is_dec;
   logic                           is_oct;
   logic                           is_low;
   logic                           is_up;
   logic [plp_pkg::CharWidth-1:0]  num_off;
   logic [plp_pkg::CharWidth-1:0]  low_off;
   logic [plp_pkg::CharWidth-1:0]  up_off;

   assign is_dec  = (char_byte >= plp_pkg::CHAR_ZERO) && (char_byte <= plp_pkg::CHAR_NINE);
   assign is_oct  = (char_byte >= plp_pkg::CHAR_ZERO) && (char_byte <= plp_pkg::CHAR_SEVEN);
   assign is_low  = (char_byte >= plp_pkg::CHAR_LOW_A) && (char_byte <= plp_pkg::CHAR_LOW_F);
   assign is_up   = (char_byte >= plp_pkg::CHAR_UP_A) && (char_byte <= plp_pkg::CHAR_UP_F);
   assign num_off = char_byte - plp_pkg::CHAR_ZERO;
   assign low_off = char_byte - plp_pkg::CHAR_LOW_A + plp_pkg::LETTER_BIAS;
   assign up_off  = char_byte - plp_pkg::CHAR_UP_A + plp_pkg::LETTER_BIAS;

   always_comb begin
      digit.hit   = 1'b0;
      digit.value = num_off[plp_pkg::DigitWidth-1:0];
      case (base_sel)
         plp_pkg::BASE_HEX: begin
            if (is_dec) begin
               digit.hit = 1'b1;
            end else if (is_low) begin
               digit.hit   = 1'b1;
               digit.value = low_off[plp_pkg::DigitWidth-1:0];
            end else if (is_up) begin
               digit.hit   = 1'b1;
               digit.value = up_off[plp_pkg::DigitWidth-1:0];
            end
         end
         plp_pkg::BASE_OCT: begin
            digit.hit = is_oct;
         end
         default: begin
            digit.hit = is_dec;
         end
      endcase
   end

endmodule

FILE: hw/rtl/plp_mac.sv
// acc * base + digit over 128 bits with carry-out detect, shift-add form
module plp_mac (
   input  logic [plp_pkg::AccWidth-1:0]   acc,
   input  plp_pkg::base_type              base_sel,
   input  logic [plp_pkg::DigitWidth-1:0] digit_value,
   output logic [plp_pkg::AccWidth-1:0]   sum,
   output logic                           carry
);

   logic [plp_pkg::WideWidth-1:0] wide;
   logic [plp_pkg::WideWidth-1:0] scaled;
   logic [plp_pkg::WideWidth-1:0] total;

   assign wide = {{plp_pkg::CarryWidth{1'b0}}, acc};

   always_comb begin
      case (base_sel)
         plp_pkg::BASE_HEX: scaled = wide << 4;
         plp_pkg::BASE_OCT: scaled = wide << 3;
         default:           scaled = (wide << 3) + (wide << 1);
      endcase
   end

   assign total = scaled + {{(plp_pkg::WideWidth-plp_pkg::DigitWidth){1'b0}}, digit_value};
   assign sum   = total[plp_pkg::AccWidth-1:0];
   assign carry = |total[plp_pkg::WideWidth-1:plp_pkg::AccWidth];

endmodule

FILE: dv/tb_parse_128bit_integer_literal.sv
// self-checking testbench for the 128-bit integer literal parser
`timescale 1ns / 1ps

module tb_parse_128bit_integer_literal;

   localparam int RADIX_DEC       = 10;
   localparam int RADIX_HEX       = 16;
   localparam int RADIX_OCT       = 8;
   localparam int HEX_LETTER_BASE = 10;
   localparam int RANDOM_ITEMS    = 450;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 10;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   plp_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   plp_pkg::rsp_payload_type rsp_payload;

   parse_128bit_integer_literal uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // parser state mirrored by the predictor
   plp_pkg::phase_type        lit_phase = plp_pkg::PH_IDLE;
   logic [127:0]              lit_acc = '0;
   plp_pkg::base_type         lit_base = plp_pkg::BASE_DEC;
   logic [7:0]                lit_count = '0;
   logic                      lit_wrap = 1'b0;
   logic                      lit_bad = 1'b0;

   plp_pkg::rsp_payload_type  expected_numbers[$];
   plp_pkg::rsp_payload_type  want_number;
   int               error_count = 0;
   int               chars_parsed = 0;
   int               numbers_checked = 0;
   int               wraps_seen = 0;
   int               saturations_seen = 0;
   int               bad_starts_seen = 0;
   int               burst_left = 0;
   int               idle_cycles = 0;
   int               stall_mode = 0;
   int               stall_left = 0;
   int               stall_tick = 0;

   function automatic int digit_value(input logic [7:0] c, input plp_pkg::base_type b);
      if (c >= plp_pkg::CHAR_ZERO && c <= plp_pkg::CHAR_NINE &&
          (b != plp_pkg::BASE_OCT || c <= plp_pkg::CHAR_SEVEN))
         return int'(c - plp_pkg::CHAR_ZERO);
      if (b == plp_pkg::BASE_HEX && c >= plp_pkg::CHAR_LOW_A && c <= plp_pkg::CHAR_LOW_F)
         return int'(c - plp_pkg::CHAR_LOW_A) + HEX_LETTER_BASE;
      if (b == plp_pkg::BASE_HEX && c >= plp_pkg::CHAR_UP_A && c <= plp_pkg::CHAR_UP_F)
         return int'(c - plp_pkg::CHAR_UP_A) + HEX_LETTER_BASE;
      return -1;
   endfunction

   function automatic int radix_of(input plp_pkg::base_type b);
      case (b)
         plp_pkg::BASE_HEX: return RADIX_HEX;
         plp_pkg::BASE_OCT: return RADIX_OCT;
         default:           return RADIX_DEC;
      endcase
   endfunction

   task automatic accumulate_digit(input int digit);
      logic [131:0] wide;
      wide = {4'b0, lit_acc} * 132'(radix_of(lit_base)) + 132'(digit);
      if (wide[131:128] != '0) lit_wrap = 1'b1;
      lit_acc = wide[127:0];
      if (lit_count != plp_pkg::COUNT_MAX) lit_count++;
   endtask

   task automatic finish_number();
      plp_pkg::rsp_payload_type n;
      n.value_low   = lit_acc[63:0];
      n.value_high  = lit_acc[127:64];
      n.base_code   = lit_base;
      n.digit_count = lit_count;
      n.not_integer = lit_bad;
      n.overflowed  = lit_wrap;
      expected_numbers.push_back(n);
      lit_phase = plp_pkg::PH_IDLE;
   endtask

   task automatic parse_char(input plp_pkg::req_payload_type item);
      int d;
      if (item.start_flag) begin
         lit_phase = plp_pkg::PH_IDLE;
         lit_acc   = '0;
         lit_base  = plp_pkg::BASE_DEC;
         lit_count = '0;
         lit_wrap  = 1'b0;
         lit_bad   = 1'b0;
         d = digit_value(item.char_byte, plp_pkg::BASE_DEC);
         if (item.char_byte == plp_pkg::CHAR_ZERO) begin
            lit_phase = plp_pkg::PH_ZERO;
         end else if (d < 0) begin
            lit_bad = 1'b1;
            finish_number();
         end else begin
            accumulate_digit(d);
            lit_phase = plp_pkg::PH_DIGITS;
         end
      end else if (lit_phase == plp_pkg::PH_ZERO) begin
         if (item.char_byte == plp_pkg::CHAR_X) begin
            lit_base  = plp_pkg::BASE_HEX;
            lit_phase = plp_pkg::PH_DIGITS;
         end else if (item.char_byte == plp_pkg::CHAR_NUL) begin
            lit_base  = plp_pkg::BASE_DEC;
            lit_count = plp_pkg::COUNT_ONE;
            finish_number();
         end else begin
            lit_base = plp_pkg::BASE_OCT;
            d = digit_value(item.char_byte, plp_pkg::BASE_OCT);
            if (d < 0) begin
               finish_number();
            end else begin
               accumulate_digit(d);
               lit_phase = plp_pkg::PH_DIGITS;
            end
         end
      end else if (lit_phase == plp_pkg::PH_DIGITS) begin
         d = digit_value(item.char_byte, lit_base);
         if (d < 0) finish_number();
         else accumulate_digit(d);
      end
   endtask

   // one character beat; called and returns at a falling edge
   task automatic send_char(input logic [7:0] c, input logic start);
      plp_pkg::req_payload_type item;
      item.char_byte  = c;
      item.start_flag = start;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (start || lit_phase != plp_pkg::PH_IDLE) chars_parsed++;
      parse_char(item);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic start_first);
      for (int i = 0; i < s.len(); i++) send_char(s[i], start_first && i == 0);
   endtask

   function automatic logic [7:0] random_digit(input plp_pkg::base_type b);
      int v;
      v = $urandom_range(0, radix_of(b) - 1);
      if (v < HEX_LETTER_BASE) return plp_pkg::CHAR_ZERO + 8'(v);
      if ($urandom_range(0, 1)) return plp_pkg::CHAR_LOW_A + 8'(v - HEX_LETTER_BASE);
      return plp_pkg::CHAR_UP_A + 8'(v - HEX_LETTER_BASE);
   endfunction

   function automatic logic [7:0] random_non_digit(input plp_pkg::base_type b);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (digit_value(c, b) >= 0);
      return c;
   endfunction

   task automatic test_directed();
      send_char("5", 1'b0);                // idle without start: dropped
      send_char("q", 1'b1);                // leading non-digit
      send_char(plp_pkg::CHAR_NUL, 1'b1);  // leading nul
      send_char(8'h80, 1'b1);              // high byte as first character
      send_text("0", 1'b1);
      send_char(plp_pkg::CHAR_NUL, 1'b0);  // lone zero
      send_text("0xg", 1'b1);              // hex prefix with no digits
      send_text("09", 1'b1);               // octal prefix with no digits
      send_text("0xfF", 1'b1);
      send_char(plp_pkg::CHAR_NUL, 1'b0);
      send_text("017 ", 1'b1);
      send_text("12", 1'b1);
      send_text("3", 1'b1);                // restart drops the literal in progress
      send_char(plp_pkg::CHAR_NUL, 1'b0);
      send_text("1", 1'b1);
      send_char(8'hFF, 1'b0);              // high byte ends a number
      send_text("0xA9G", 1'b1);
   endtask

   task automatic test_wide_values();
      // largest value in each base, then one past it in hex and decimal
      send_text("0x", 1'b1);
      repeat (32) send_char("f", 1'b0);
      send_char(plp_pkg::CHAR_NUL, 1'b0);
      send_text("0x1", 1'b1);
      repeat (32) send_char("0", 1'b0);
      send_char(plp_pkg::CHAR_NUL, 1'b0);
      send_text("340282366920938463463374607431768211455", 1'b1);
      send_char(plp_pkg::CHAR_NUL, 1'b0);
      send_text("340282366920938463463374607431768211456", 1'b1);
      send_char(plp_pkg::CHAR_NUL, 1'b0);
      send_text("03", 1'b1);
      repeat (42) send_char("7", 1'b0);
      send_char(plp_pkg::CHAR_NUL, 1'b0);
      // digit count saturation
      send_text("1", 1'b1);
      repeat (300) send_char("0", 1'b0);
      send_char(plp_pkg::CHAR_NUL, 1'b0);
   endtask

   task automatic test_random_literals();
      int first_item;
      int kind;
      int n;
      int r;
      plp_pkg::base_type b;
      first_item = chars_parsed;
      while (chars_parsed - first_item < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         r = $urandom_range(0, 99);
         n = (r < 85) ? $urandom_range(0, 12) :
             (r < 98) ? $urandom_range(13, 45) : $urandom_range(250, 270);
         if (kind <= 3) begin
            b = plp_pkg::BASE_DEC;
            send_char(plp_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)), 1'b1);
         end else if (kind <= 5) begin
            b = plp_pkg::BASE_HEX;
            send_text("0x", 1'b1);
         end else if (kind <= 7) begin
            b = plp_pkg::BASE_OCT;
            send_text("0", 1'b1);
         end else if (kind == 8) begin
            n = 0;
            b = plp_pkg::BASE_DEC;
            if ($urandom_range(0, 1)) send_text("0", 1'b1);
            else send_char(random_non_digit(plp_pkg::BASE_DEC), 1'b1);
         end else begin
            // noise: any byte, start now and then
            repeat ($urandom_range(1, 8))
               send_char(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 25);
            continue;
         end
         repeat (n) send_char(random_digit(b), 1'b0);
         r = $urandom_range(0, 99);
         if (r < 40) send_char(plp_pkg::CHAR_NUL, 1'b0);
         else if (r < 85) send_char(random_non_digit(b), 1'b0);
         if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // result side stalls in stretches of changing character
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 120);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 99) < 30);
         2:       rsp_stall <= ($urandom_range(0, 99) < 75);
         default: rsp_stall <= ((stall_tick % 5) < 2);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_numbers.size() == 0) begin
            $error("result beat with no expected number pending");
            error_count++;
         end else begin
            want_number = expected_numbers.pop_front();
            numbers_checked++;
            if (want_number.overflowed) wraps_seen++;
            if (want_number.digit_count == plp_pkg::COUNT_MAX) saturations_seen++;
            if (want_number.not_integer) bad_starts_seen++;
            if (rsp_payload.value_low !== want_number.value_low) begin
               $error("value_low expected %h actual %h",
                      want_number.value_low, rsp_payload.value_low);
               error_count++;
            end
            if (rsp_payload.value_high !== want_number.value_high) begin
               $error("value_high expected %h actual %h",
                      want_number.value_high, rsp_payload.value_high);
               error_count++;
            end
            if (rsp_payload.base_code !== want_number.base_code) begin
               $error("base_code expected %0d actual %0d",
                      want_number.base_code, rsp_payload.base_code);
               error_count++;
            end
            if (rsp_payload.digit_count !== want_number.digit_count) begin
               $error("digit_count expected %0d actual %0d",
                      want_number.digit_count, rsp_payload.digit_count);
               error_count++;
            end
            if (rsp_payload.not_integer !== want_number.not_integer) begin
               $error("not_integer expected %0b actual %0b",
                      want_number.not_integer, rsp_payload.not_integer);
               error_count++;
            end
            if (rsp_payload.overflowed !== want_number.overflowed) begin
               $error("overflowed expected %0b actual %0b",
                      want_number.overflowed, rsp_payload.overflowed);
               error_count++;
            end
         end
      end
   end

   // watchdog: no beat on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_wide_values();
      test_random_literals();
      req_valid <= 1'b0;
      wait (expected_numbers.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_numbers.size() != 0) begin
         $error("%0d expected numbers never arrived", expected_numbers.size());
         error_count++;
      end
      $display("parsed %0d characters into %0d checked numbers",
               chars_parsed, numbers_checked);
      $display("%0d wrapped, %0d with saturated count, %0d not integers",
               wraps_seen, saturations_seen, bad_starts_seen);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
